/* rtl/one_wire_rom_search_engine_assert.svh */
// Assertion macros used by the checker file of the ROM search engine.
// Every assertion is clocked on aclk and is disabled while aresetn is low.
`ifndef ONE_WIRE_ROM_SEARCH_ENGINE_ASSERT_SVH
`define ONE_WIRE_ROM_SEARCH_ENGINE_ASSERT_SVH

// A general property, sampled at the rising edge of the clock.
`define OWS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("one_wire_rom_search_engine: assertion failed");

// A condition that must hold for every result transaction on offer.
`define OWS_ASSERT_RESULT(lbl, cond) \
    `OWS_ASSERT(lbl, m_valid |-> (cond))

`endif

/* rtl/ows_pkg.sv */
`default_nettype none

package ows_pkg;

    // Command codes of an input transaction.
    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_BIT    = 3'd1;
    localparam logic [2:0] CMD_RESET  = 3'd2;
    localparam logic [2:0] CMD_TARGET = 3'd3;
    localparam logic [2:0] CMD_SKIP   = 3'd4;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_ACK      = 2'd0;
    localparam logic [1:0] ST_CONTINUE = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_FAIL     = 2'd3;

    // Reflected Dallas CRC-8 polynomial.
    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [6:0] ROM_BITS     = 7'd64;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;

    typedef struct packed {
        logic [2:0] command;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
        logic [7:0] family_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        direction;
        logic [6:0]  bit_position;
        logic [63:0] found_rom;
        logic        last_device;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/ows_in_stage.sv */
`default_nettype none

module ows_in_stage (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  ows_pkg::in_item_t s_item,
    input  wire               advance,
    output logic              in_valid,
    output ows_pkg::in_item_t in_item
);
    import ows_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The register can take a new transaction whenever its content moves on.
    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/ows_core.sv */
`default_nettype none

module ows_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                fire,
    input  ows_pkg::in_item_t  item,
    output ows_pkg::out_item_t result
);
    import ows_pkg::*;

    logic [63:0] rom_reg, rom_next;
    logic [6:0]  ld_reg, ld_next;
    logic [3:0]  lfd_reg, lfd_next;
    logic        ldf_reg, ldf_next;
    logic [6:0]  lzp_reg, lzp_next;
    logic [6:0]  bitcnt_reg, bitcnt_next;
    logic [7:0]  crc_reg, crc_next;
    logic        active_reg, active_next;

    logic        do_clear;
    logic        do_idle;
    logic        dir;
    logic [6:0]  pos;
    logic [5:0]  idx;
    out_item_t   res;

    assign pos    = bitcnt_reg;
    assign idx    = pos[5:0] - 6'd1;
    assign result = res;

    always_comb begin
        rom_next    = rom_reg;
        ld_next     = ld_reg;
        lfd_next    = lfd_reg;
        ldf_next    = ldf_reg;
        lzp_next    = lzp_reg;
        bitcnt_next = bitcnt_reg;
        crc_next    = crc_reg;
        active_next = active_reg;
        do_clear    = 1'b0;
        do_idle     = 1'b0;
        dir         = 1'b0;
        res         = '0;

        unique case (item.command)
            CMD_BEGIN: begin
                do_idle = 1'b1;
                if (ldf_reg || !item.presence) begin
                    do_clear   = 1'b1;
                    res.status = ST_FAIL;
                end else begin
                    active_next = 1'b1;
                end
            end
            CMD_BIT: begin
                if (active_reg) begin
                    if (item.id_bit && item.complement_bit) begin
                        // Nobody drove the bus low: no device took part.
                        do_clear   = 1'b1;
                        do_idle    = 1'b1;
                        res.status = ST_FAIL;
                    end else begin
                        if (item.id_bit != item.complement_bit) begin
                            dir = item.id_bit;
                        end else begin
                            // Discrepancy: follow the previous path below the
                            // last discrepancy, take one at it, zero beyond it.
                            if (pos < ld_reg) begin
                                dir = rom_reg[idx];
                            end else begin
                                dir = (pos == ld_reg);
                            end
                            if (!dir) begin
                                lzp_next = pos;
                                if (pos < FAMILY_LIMIT) begin
                                    lfd_next = pos[3:0];
                                end
                            end
                        end
                        rom_next[idx]    = dir;
                        crc_next         = {1'b0, crc_reg[7:1]}
                                           ^ ((crc_reg[0] ^ dir) ? CRC_POLY : 8'h00);
                        res.direction    = dir;
                        res.bit_position = pos;
                        if (pos >= ROM_BITS) begin
                            do_idle = 1'b1;
                            if (crc_next != 8'h00) begin
                                do_clear   = 1'b1;
                                res.status = ST_FAIL;
                            end else begin
                                ld_next = lzp_next;
                                if (lzp_next == 7'd0) begin
                                    ldf_next = 1'b1;
                                end
                                if (rom_next[7:0] == 8'h00) begin
                                    do_clear   = 1'b1;
                                    res.status = ST_FAIL;
                                end else begin
                                    res.status      = ST_FOUND;
                                    res.found_rom   = rom_next;
                                    res.last_device = ldf_next;
                                end
                            end
                        end else begin
                            bitcnt_next = pos + 7'd1;
                            res.status  = ST_CONTINUE;
                        end
                    end
                end
            end
            CMD_RESET: begin
                do_clear = 1'b1;
                do_idle  = 1'b1;
            end
            CMD_TARGET: begin
                rom_next = {56'd0, item.family_code};
                ld_next  = ROM_BITS;
                lfd_next = 4'd0;
                ldf_next = 1'b0;
                do_idle  = 1'b1;
            end
            CMD_SKIP: begin
                ld_next  = {3'd0, lfd_reg};
                lfd_next = 4'd0;
                if (lfd_reg == 4'd0) begin
                    ldf_next = 1'b1;
                end
                do_idle = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_clear) begin
            rom_next = '0;
            ld_next  = '0;
            lfd_next = '0;
            ldf_next = 1'b0;
        end
        if (do_idle) begin
            active_next = active_next && (item.command == CMD_BEGIN) && !do_clear;
            bitcnt_next = 7'd1;
            lzp_next    = '0;
            crc_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_reg    <= '0;
            ld_reg     <= '0;
            lfd_reg    <= '0;
            ldf_reg    <= 1'b0;
            lzp_reg    <= '0;
            bitcnt_reg <= 7'd1;
            crc_reg    <= '0;
            active_reg <= 1'b0;
        end else if (fire) begin
            rom_reg    <= rom_next;
            ld_reg     <= ld_next;
            lfd_reg    <= lfd_next;
            ldf_reg    <= ldf_next;
            lzp_reg    <= lzp_next;
            bitcnt_reg <= bitcnt_next;
            crc_reg    <= crc_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/one_wire_rom_search_engine.sv */
// Master-side 1-Wire ROM search engine. Each input transaction is one command
// (begin, bit pair, reset search, target family, skip family) and produces
// exactly one result transaction. The block takes one transaction per cycle
// unless a result is stalled by m_ready low; each passes through the input
// register and then the result register. Each command reads and writes the
// search state (stored ROM, discrepancy markers, bit counter and CRC-8) in the
// cycle it leaves the input register. No clearing pass follows reset; the
// block is ready at once.
`default_nettype none

module one_wire_rom_search_engine (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  ows_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  wire                m_ready,
    output ows_pkg::out_item_t m_item
);
    import ows_pkg::*;

    logic      in_valid;
    in_item_t  in_item;
    logic      fire;
    out_item_t result;
    logic      m_valid_reg;
    out_item_t m_item_reg;

    // A command executes when the result register is empty or being emptied.
    assign fire = in_valid && (!m_valid_reg || m_ready);

    ows_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (fire),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    ows_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* rtl/ows_checker.sv */
`default_nettype none

module ows_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input ows_pkg::in_item_t  s_item,
    input wire                m_valid,
    input wire                m_ready,
    input ows_pkg::out_item_t m_item
);
    import ows_pkg::*;

`include "one_wire_rom_search_engine_assert.svh"

    // A stalled result transaction keeps its content.
    `OWS_ASSERT(a_result_held, (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))

    // A found device always carries a nonzero family byte.
    `OWS_ASSERT_RESULT(a_found_family, (m_item.status != ST_FOUND) || (m_item.found_rom[7:0] != 8'h00))

    // Only a found device reports a ROM code or the last-device flag.
    `OWS_ASSERT_RESULT(a_rom_only_found, (m_item.status == ST_FOUND) || ((m_item.found_rom == 64'd0) && !m_item.last_device))

    // A continuing search has decided a bit below the last one.
    `OWS_ASSERT_RESULT(a_continue_pos, (m_item.status != ST_CONTINUE) || ((m_item.bit_position != 7'd0) && (m_item.bit_position < ROM_BITS)))

endmodule

bind one_wire_rom_search_engine ows_checker u_ows_checker (.*);

`default_nettype wire
